// ===== hw/rtl/rzba_pkg.sv =====
package rzba_pkg;

    // Request codes carried in the req_type field.
    typedef enum logic [1:0] {
        REQ_STRIPE = 2'd0,
        REQ_MIRROR = 2'd1,
        REQ_SINGLE = 2'd2,
        REQ_ADD    = 2'd3
    } req_type_t;

    // Configuration register indexes.
    localparam logic CFG_DEVICE_COUNT = 1'b0;
    localparam logic CFG_ZONE_COUNT   = 1'b1;

    localparam int CFG_DATA_W = 11;

    localparam logic [3:0]  DEVICE_COUNT_RST = 4'd8;
    localparam logic [10:0] ZONE_COUNT_RST   = 11'd1024;

    // Response status codes.
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NO_SPACE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_FINAL
    } state_t;

    typedef struct packed {
        req_type_t   req_type;
        logic [9:0]  logical_zone;
        logic [12:0] sub_index;
        logic [2:0]  device;
        logic [9:0]  zone;
    } req_t;

    typedef struct packed {
        logic        mapping_valid;
        logic [12:0] out_sub_index;
        logic [2:0]  out_device;
        logic [9:0]  out_zone;
        logic        status;
        logic        last;
    } rsp_t;

endpackage

// ===== hw/rtl/raid_zone_bitmap_allocator_top.sv =====
// An allocation reads row 0 in ST_START and offers its mappings from ST_SCAN, moving to the
// next zone after each fully used row; an explicit add reads its row in ST_ADD_RD and offers
// its mapping from ST_ADD_WR, and a shortfall or a request that needs no scan answers from ST_FINAL.
// One request at a time: the request port reopens only once the sequencer is back in ST_IDLE,
// and a result that is not taken holds the sequencer in the state that offers the next one.
// Reset (rst_n, asynchronous, active low) clears control state and then sweeps MAX_ZONES rows.
module raid_zone_bitmap_allocator_top
    import rzba_pkg::*;
#(
    parameter int MAX_DEVICES = 8,
    parameter int MAX_ZONES   = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_t                  rsp,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // The used bitmap is kept as one RAM row per zone, one bit per device.
    // After reset the sequencer sweeps every row to zero and holds req_ready low
    // meanwhile; configuration writes are taken at any time.
    localparam int ZA  = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
    localparam int ZCW = $clog2(MAX_ZONES + 1);
    localparam int DA  = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;

    state_t state_reg, state_next;

    logic [3:0]  device_count_reg;
    logic [10:0] zone_count_reg;

    // Request context captured when a transaction is accepted.
    req_type_t              type_reg,   type_next;
    logic [12:0]            base_reg,   base_next;
    logic [12:0]            sub_reg,    sub_next;
    logic [2:0]             dev_reg,    dev_next;
    logic [9:0]             zn_reg,     zn_next;
    logic [MAX_DEVICES-1:0] mask_reg,   mask_next;
    logic [4:0]             need_reg,   need_next;
    logic [4:0]             got_reg,    got_next;
    logic                   fin_status_reg, fin_status_next;

    // Scan state: current zone, the working copy of its row, and whether the
    // row still has to be taken from the RAM read port.
    logic [ZA-1:0]          zone_ptr_reg, zone_ptr_next;
    logic [MAX_DEVICES-1:0] row_reg,      row_next;
    logic                   fresh_reg,    fresh_next;

    rsp_t rsp_reg,       rsp_next;
    logic rsp_valid_reg, rsp_valid_next;

    // RAM port controls.
    logic                   ram_we;
    logic [ZA-1:0]          ram_waddr;
    logic [MAX_DEVICES-1:0] ram_wdata;
    logic                   ram_re;
    logic [ZA-1:0]          ram_raddr;
    logic [MAX_DEVICES-1:0] ram_rdata;

    // Effective register values, clipped to the built size.
    logic [3:0]     dc_eff;
    logic [16:0]    zc_wide;
    logic [ZCW-1:0] zc_eff;

    logic                   out_free;
    logic                   accept;
    logic                   dev_in_range;
    logic                   zn_in_range;
    logic [MAX_DEVICES-1:0] stripe_mask;
    logic [MAX_DEVICES-1:0] req_dev_hot;
    logic [MAX_DEVICES-1:0] reg_dev_hot;
    logic [13:0]            base_prod;

    logic [MAX_DEVICES-1:0] row_cur;
    logic [MAX_DEVICES-1:0] free_bits;
    logic [MAX_DEVICES-1:0] take_hot;
    logic                   pick_found;
    logic [DA-1:0]          pick_index;
    logic [DA+2:0]          pick_ext;
    logic                   take;
    logic                   need_met;
    logic [ZCW-1:0]         zone_ptr_inc;
    logic                   last_zone;
    logic                   clear_done;
    logic [ZA+9:0]          zone_ext;
    logic [ZA+9:0]          add_addr_ext;
    logic [4:0]             sub_k;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_count_reg <= DEVICE_COUNT_RST;
            zone_count_reg   <= ZONE_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEVICE_COUNT: device_count_reg <= cfg_data[3:0];
                CFG_ZONE_COUNT:   zone_count_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign dc_eff  = (6'(device_count_reg) > 6'(MAX_DEVICES)) ? 4'(MAX_DEVICES)
                                                             : device_count_reg;
    assign zc_wide = (17'(zone_count_reg) > 17'(MAX_ZONES)) ? 17'(MAX_ZONES)
                                                           : 17'(zone_count_reg);
    assign zc_eff  = zc_wide[ZCW-1:0];

    // ------------------------------------------------------------------
    // Shared row search: lowest free device in the current row among those
    // the request may use.
    // ------------------------------------------------------------------
    assign row_cur   = fresh_reg ? ram_rdata : row_reg;
    assign free_bits = ~row_cur & mask_reg;
    assign take_hot  = free_bits & (~free_bits + MAX_DEVICES'(1));

    rzba_pick #(
        .WIDTH (MAX_DEVICES)
    ) u_pick (
        .free  (free_bits),
        .found (pick_found),
        .index (pick_index)
    );

    assign pick_ext = {3'd0, pick_index};

    always_comb
    begin
        for (int i = 0; i < MAX_DEVICES; i++)
        begin
            stripe_mask[i] = 6'(i) < 6'(dc_eff);
            req_dev_hot[i] = 6'(i) == 6'(req.device);
            reg_dev_hot[i] = 6'(i) == 6'(dev_reg);
        end
    end

    assign out_free     = !rsp_valid_reg || rsp_ready;
    assign accept       = req_valid && req_ready;
    assign dev_in_range = 6'(req.device) < 6'(MAX_DEVICES);
    assign zn_in_range  = 17'(req.zone) < 17'(MAX_ZONES);
    assign base_prod    = 14'(req.logical_zone) * 14'(dc_eff);

    assign need_met     = got_reg == need_reg;
    assign take         = pick_found && !need_met;
    assign zone_ptr_inc = ZCW'(zone_ptr_reg) + ZCW'(1);
    assign last_zone    = zone_ptr_inc == zc_eff;
    assign clear_done   = zone_ptr_reg == ZA'(MAX_ZONES - 1);
    assign zone_ext     = {10'd0, zone_ptr_reg};
    assign add_addr_ext = {{ZA{1'b0}}, zn_reg};
    assign sub_k        = (type_reg == REQ_MIRROR) ? (got_reg >> 1) : got_reg;

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (req.req_type)
                        REQ_STRIPE, REQ_MIRROR:
                        begin
                            if (dc_eff == 4'd0 || zc_eff == '0)
                            begin
                                state_next = ST_FINAL;
                            end
                            else
                            begin
                                state_next = ST_START;
                            end
                        end
                        REQ_SINGLE:
                        begin
                            if (dev_in_range && zc_eff != '0)
                            begin
                                state_next = ST_START;
                            end
                            else
                            begin
                                state_next = ST_FINAL;
                            end
                        end
                        REQ_ADD:
                        begin
                            if (dev_in_range && zn_in_range)
                            begin
                                state_next = ST_ADD_RD;
                            end
                            else
                            begin
                                state_next = ST_FINAL;
                            end
                        end
                        default: state_next = ST_FINAL;
                    endcase
                end
            end
            ST_START: state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (!take)
                begin
                    if (need_met)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (last_zone)
                    begin
                        state_next = ST_FINAL;
                    end
                end
            end
            ST_ADD_RD: state_next = ST_ADD_WR;
            ST_ADD_WR:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FINAL:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: datapath controls and next register values.
    // ------------------------------------------------------------------
    always_comb
    begin
        type_next       = type_reg;
        base_next       = base_reg;
        sub_next        = sub_reg;
        dev_next        = dev_reg;
        zn_next         = zn_reg;
        mask_next       = mask_reg;
        need_next       = need_reg;
        got_next        = got_reg;
        fin_status_next = fin_status_reg;
        zone_ptr_next   = zone_ptr_reg;
        row_next        = row_reg;
        fresh_next      = fresh_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;

        ram_we    = 1'b0;
        ram_waddr = zone_ptr_reg;
        ram_wdata = row_cur;
        ram_re    = 1'b0;
        ram_raddr = zone_ptr_reg;

        req_ready = state_reg == ST_IDLE;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_wdata     = '0;
                zone_ptr_next = zone_ptr_reg + ZA'(1);
                if (clear_done)
                begin
                    zone_ptr_next = '0;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    type_next = req.req_type;
                    base_next = base_prod[12:0];
                    sub_next  = req.sub_index;
                    dev_next  = req.device;
                    zn_next   = req.zone;
                    got_next  = '0;
                    case (req.req_type)
                        REQ_STRIPE:
                        begin
                            mask_next       = stripe_mask;
                            need_next       = {1'b0, dc_eff};
                            fin_status_next = (dc_eff == 4'd0) ? STATUS_OK : STATUS_NO_SPACE;
                        end
                        REQ_MIRROR:
                        begin
                            mask_next       = stripe_mask;
                            need_next       = {dc_eff, 1'b0};
                            fin_status_next = (dc_eff == 4'd0) ? STATUS_OK : STATUS_NO_SPACE;
                        end
                        REQ_SINGLE:
                        begin
                            mask_next       = req_dev_hot;
                            need_next       = 5'd1;
                            fin_status_next = STATUS_NO_SPACE;
                        end
                        default:
                        begin
                            mask_next       = req_dev_hot;
                            need_next       = 5'd1;
                            fin_status_next = STATUS_OK;
                        end
                    endcase
                end
            end
            ST_START:
            begin
                ram_re        = 1'b1;
                ram_raddr     = '0;
                zone_ptr_next = '0;
                fresh_next    = 1'b1;
            end
            ST_SCAN:
            begin
                if (take)
                begin
                    if (out_free)
                    begin
                        row_next                = row_cur | take_hot;
                        fresh_next              = 1'b0;
                        got_next                = got_reg + 5'd1;
                        rsp_valid_next          = 1'b1;
                        rsp_next.mapping_valid  = 1'b1;
                        rsp_next.out_sub_index  = (type_reg == REQ_SINGLE) ? sub_reg
                                                                            : base_reg + 13'(sub_k);
                        rsp_next.out_device     = pick_ext[2:0];
                        rsp_next.out_zone       = zone_ext[9:0];
                        rsp_next.status         = STATUS_OK;
                        rsp_next.last           = (got_reg + 5'd1) == need_reg;
                    end
                end
                else
                begin
                    // Row done: write it back; next zone if more is needed and zones remain.
                    ram_we = 1'b1;
                    if (!need_met && !last_zone)
                    begin
                        ram_re        = 1'b1;
                        ram_raddr     = zone_ptr_reg + ZA'(1);
                        zone_ptr_next = zone_ptr_reg + ZA'(1);
                        fresh_next    = 1'b1;
                    end
                    if (!need_met && last_zone)
                    begin
                        fin_status_next = STATUS_NO_SPACE;
                    end
                end
            end
            ST_ADD_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = add_addr_ext[ZA-1:0];
            end
            ST_ADD_WR:
            begin
                ram_waddr = add_addr_ext[ZA-1:0];
                ram_wdata = ram_rdata | reg_dev_hot;
                if (out_free)
                begin
                    ram_we                 = 1'b1;
                    rsp_valid_next         = 1'b1;
                    rsp_next.mapping_valid = 1'b1;
                    rsp_next.out_sub_index = sub_reg;
                    rsp_next.out_device    = dev_reg;
                    rsp_next.out_zone      = zn_reg;
                    rsp_next.status        = STATUS_OK;
                    rsp_next.last          = 1'b1;
                end
            end
            ST_FINAL:
            begin
                if (out_free)
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_next.mapping_valid = 1'b0;
                    rsp_next.out_sub_index = '0;
                    rsp_next.out_device    = '0;
                    rsp_next.out_zone      = '0;
                    rsp_next.status        = fin_status_reg;
                    rsp_next.last          = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            rsp_valid_reg <= 1'b0;
            zone_ptr_reg  <= '0;
            got_reg       <= '0;
            fresh_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            zone_ptr_reg  <= zone_ptr_next;
            got_reg       <= got_next;
            fresh_reg     <= fresh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg       <= type_next;
        base_reg       <= base_next;
        sub_reg        <= sub_next;
        dev_reg        <= dev_next;
        zn_reg         <= zn_next;
        mask_reg       <= mask_next;
        need_reg       <= need_next;
        fin_status_reg <= fin_status_next;
        row_reg        <= row_next;
        rsp_reg        <= rsp_next;
    end

    rzba_ram #(
        .WIDTH (MAX_DEVICES),
        .DEPTH (MAX_ZONES)
    ) u_used_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== hw/rtl/rzba_ram.sv =====
module rzba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/rzba_pick.sv =====
module rzba_pick #(
    parameter int WIDTH = 8
) (
    input  logic [WIDTH-1:0]                             free,
    output logic                                         found,
    output logic [((WIDTH > 1) ? $clog2(WIDTH) : 1)-1:0] index
);

    localparam int IW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    // Lowest set bit wins: scan from the top so the lowest index is assigned last.
    always_comb
    begin
        index = '0;
        for (int i = WIDTH - 1; i >= 0; i--)
        begin
            if (free[i])
            begin
                index = IW'(i);
            end
        end
    end

    assign found = |free;

endmodule

// ===== hw/rtl/rzba_checker.sv =====
module rzba_checker
    import rzba_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    // A response that is not taken stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // A response without a mapping always closes its transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.mapping_valid |-> rsp.last)
        else $error("non-mapping response not marked last");

    // No space is reported only on a closing response that carries no mapping.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status |-> rsp.last && !rsp.mapping_valid)
        else $error("no-space status on a mapping or non-final response");

    // One request at a time: the block is busy right after taking a transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request port ready right after an accepted transaction");

endmodule

bind raid_zone_bitmap_allocator_top rzba_checker u_rzba_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

// ===== bench/raid_zone_bitmap_allocator_top_tb.sv =====
`timescale 1ns / 1ps

module raid_zone_bitmap_allocator_top_tb;
    import rzba_pkg::*;

    // Sizes of the used bitmap, matched to the instance below.
    localparam int NUM_DEVICES = 8;
    localparam int NUM_ZONES   = 1024;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 7;

    // The slowest legal stretch without any transaction is the clearing sweep after
    // reset, or a full zone scan that sits behind the long receiver hold-off.  The
    // watchdog limit is several times the sum.
    localparam int STALL_LIMIT = 20000;

    // The receiver holds off once for this many cycles after this many results.
    localparam int LONG_HOLDOFF  = 500;
    localparam int HOLDOFF_AFTER = 100;

    // Quiet cycles before a register write and at the end of the run.
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 40;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    req_t                  req       = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    rsp_t                  rsp;
    logic                  cfg_we    = 1'b0;
    logic                  cfg_index = CFG_DEVICE_COUNT;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Shadow of the allocator: one used flag per (device, zone) pair and the two
    // configuration registers as the block holds them.
    bit          pair_used [NUM_DEVICES][NUM_ZONES];
    logic [3:0]  device_count_reg = DEVICE_COUNT_RST;
    logic [10:0] zone_count_reg   = ZONE_COUNT_RST;

    // Mappings still owed by the block, oldest first, and requests not yet offered.
    rsp_t expected_maps [$];
    req_t pending_reqs [$];

    int reqs_queued    = 0;
    int reqs_accepted  = 0;
    int maps_received  = 0;
    int error_count    = 0;
    int idle_cycles    = 0;
    int req_gap_pct    = 30;
    int rsp_stall_pct  = 30;
    int gap_left       = 0;
    int rsp_wait       = 0;
    bit req_taken      = 1'b0;
    bit holdoff_done   = 1'b0;

    raid_zone_bitmap_allocator_top #(
        .MAX_DEVICES (NUM_DEVICES),
        .MAX_ZONES   (NUM_ZONES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // Register values above the array size act as the array size.
    function automatic int active_devices();
        return (int'(device_count_reg) > NUM_DEVICES) ? NUM_DEVICES : int'(device_count_reg);
    endfunction

    function automatic int active_zones();
        return (int'(zone_count_reg) > NUM_ZONES) ? NUM_ZONES : int'(zone_count_reg);
    endfunction

    function automatic void push_map(input logic valid, input logic [12:0] sub,
                                     input logic [2:0] dev, input logic [9:0] zone,
                                     input logic status, input logic last);
        rsp_t m;
        m.mapping_valid = valid;
        m.out_sub_index = sub;
        m.out_device    = dev;
        m.out_zone      = zone;
        m.status        = status;
        m.last          = last;
        expected_maps.push_back(m);
    endfunction

    // First-fit allocation on the shadow bitmap.  Each request appends every mapping it
    // produces to expected_maps, with the terminating result where one is due.
    function automatic void allocate_expected(input req_t r);
        int dc;
        int zc;
        int need;
        int got;
        bit mirrored;
        dc = active_devices();
        zc = active_zones();
        case (r.req_type)
            REQ_STRIPE, REQ_MIRROR:
            begin
                // Zone-major scan: all devices of a zone before the next zone.  A
                // mirrored stripe places two copies of each sub-index.
                mirrored = (r.req_type == REQ_MIRROR);
                need = mirrored ? 2 * dc : dc;
                got = 0;
                for (int z = 0; z < zc && got < need; z++)
                begin
                    for (int d = 0; d < dc && got < need; d++)
                    begin
                        if (!pair_used[d][z])
                        begin
                            pair_used[d][z] = 1'b1;
                            push_map(1'b1,
                                     13'(int'(r.logical_zone) * dc + (mirrored ? got / 2 : got)),
                                     3'(d), 10'(z), STATUS_OK, (got + 1 == need));
                            got++;
                        end
                    end
                end
                // A shortfall keeps what was taken and closes with no space; a stripe
                // width of zero needs nothing and closes with an empty ok result.
                if (got < need)
                    push_map(1'b0, '0, '0, '0, STATUS_NO_SPACE, 1'b1);
                else if (need == 0)
                    push_map(1'b0, '0, '0, '0, STATUS_OK, 1'b1);
            end
            REQ_SINGLE:
            begin
                // The device need not lie below device_count.
                got = 0;
                for (int z = 0; z < zc && got == 0; z++)
                begin
                    if (!pair_used[r.device][z])
                    begin
                        pair_used[r.device][z] = 1'b1;
                        push_map(1'b1, r.sub_index, r.device, 10'(z), STATUS_OK, 1'b1);
                        got = 1;
                    end
                end
                if (got == 0)
                    push_map(1'b0, '0, '0, '0, STATUS_NO_SPACE, 1'b1);
            end
            default:
            begin
                // An explicit add marks the pair unconditionally, even beyond zone_count.
                // Field widths keep device and zone inside the array.
                pair_used[r.device][r.zone] = 1'b1;
                push_map(1'b1, r.sub_index, r.device, r.zone, STATUS_OK, 1'b1);
            end
        endcase
    endfunction

    function automatic req_t make_req(input req_type_t kind, input int logical, input int sub,
                                      input int dev, input int zone);
        req_t r;
        r.req_type     = kind;
        r.logical_zone = 10'(logical);
        r.sub_index    = 13'(sub);
        r.device       = 3'(dev);
        r.zone         = 10'(zone);
        return r;
    endfunction

    // Random request.  Explicit adds mostly target zones inside zone_count so they
    // collide with later scans; the rest land anywhere in the array.
    function automatic req_t random_req();
        req_t r;
        int pick;
        int zc;
        pick = $urandom_range(99);
        if (pick < 35)
            r.req_type = REQ_STRIPE;
        else if (pick < 60)
            r.req_type = REQ_MIRROR;
        else if (pick < 80)
            r.req_type = REQ_SINGLE;
        else
            r.req_type = REQ_ADD;
        r.logical_zone = 10'($urandom_range(1023));
        r.sub_index    = 13'($urandom_range(8191));
        r.device       = 3'($urandom_range(7));
        zc = active_zones();
        if (zc > 0 && $urandom_range(3) != 0)
            r.zone = 10'($urandom_range(zc - 1));
        else
            r.zone = 10'($urandom_range(1023));
        return r;
    endfunction

    // Idle length: usually none, otherwise mostly short with an occasional long gap.
    function automatic int idle_length(input int pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(9) < 8)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    task automatic queue_req(input req_t r);
        pending_reqs.push_back(r);
        reqs_queued++;
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
            queue_req(random_req());
    endtask

    task automatic check_field(input string name, input logic [12:0] want,
                               input logic [12:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    // Blocks until every queued request has been taken and every mapping it owes has
    // come back.  Both counters move only at rising edges, so sampling at the falling
    // edge is free of races.  Every request ends in a last result, so a short settle
    // is enough before the block can be treated as idle.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (reqs_accepted != reqs_queued || expected_maps.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_DEVICE_COUNT)
            device_count_reg = value[3:0];
        else
            zone_count_reg = value;
    endtask

    // A new phase starts only with the block idle; both registers are rewritten and the
    // idling of both sides is set for the phase.
    task automatic start_phase(input int devices, input int zones, input int gap_pct,
                               input int stall_pct);
        wait_drained();
        write_reg(CFG_DEVICE_COUNT, CFG_DATA_W'(devices));
        write_reg(CFG_ZONE_COUNT, CFG_DATA_W'(zones));
        req_gap_pct   = gap_pct;
        rsp_stall_pct = stall_pct;
    endtask

    // Request driver.  A request stays on the bus until its transaction completes; only
    // then does the driver either idle for the chosen gap or present the next request.
    always @(negedge clk)
    begin : request_driver
        if (rst_n && (!req_valid || req_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                req_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                req       <= pending_reqs.pop_front();
                req_valid <= 1'b1;
                gap_left   = idle_length(req_gap_pct);
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // Result receiver.  Random stalls, plus one long hold-off so that the block backs
    // up and has to keep its request port closed while new requests wait.
    always @(negedge clk)
    begin : response_sink
        if (!holdoff_done && maps_received >= HOLDOFF_AFTER)
        begin
            holdoff_done = 1'b1;
            rsp_wait     = LONG_HOLDOFF;
        end
        if (rsp_wait > 0)
        begin
            rsp_wait--;
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_wait = idle_length(rsp_stall_pct);
            rsp_ready <= (rsp_wait == 0);
        end
    end

    // Checker and watchdog, at the rising edge.  The result transaction is checked
    // before a request transaction of the same edge is predicted; a request can never
    // answer in the cycle it is taken, so the order only keeps the queue tidy.
    always @(posedge clk)
    begin : scoreboard
        rsp_t want;
        if (rst_n)
        begin
            req_taken = req_valid && req_ready;
            if (rsp_valid && rsp_ready)
            begin
                maps_received++;
                if (expected_maps.size() == 0)
                begin
                    $error("result transaction with nothing outstanding: %p", rsp);
                    error_count++;
                end
                else
                begin
                    want = expected_maps.pop_front();
                    check_field("mapping_valid", want.mapping_valid, rsp.mapping_valid);
                    check_field("out_sub_index", want.out_sub_index, rsp.out_sub_index);
                    check_field("out_device", want.out_device, rsp.out_device);
                    check_field("out_zone", want.out_zone, rsp.out_zone);
                    check_field("status", want.status, rsp.status);
                    check_field("last", want.last, rsp.last);
                end
            end
            if (req_taken)
            begin
                reqs_accepted++;
                allocate_expected(req);
            end
            if (req_taken || (rsp_valid && rsp_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Reset configuration: eight devices, all zones.  Plain and mirrored stripes at
        // both ends of the logical range, singles on the first and last device, adds at
        // the array corners and onto an already used pair, and a stripe that has to
        // skip pairs marked by singles.
        queue_req(make_req(REQ_STRIPE, 0, 0, 0, 0));
        queue_req(make_req(REQ_MIRROR, 1023, 0, 0, 0));
        queue_req(make_req(REQ_SINGLE, 0, 8191, 0, 0));
        queue_req(make_req(REQ_SINGLE, 1023, 0, 7, 1023));
        queue_req(make_req(REQ_ADD, 0, 8191, 7, 1023));
        queue_req(make_req(REQ_ADD, 0, 0, 0, 0));
        queue_req(make_req(REQ_ADD, 0, 4660, 3, 4));
        queue_req(make_req(REQ_STRIPE, 1, 0, 0, 0));
        queue_req(make_req(REQ_SINGLE, 0, 2730, 3, 0));
        queue_req(make_req(REQ_ADD, 1023, 5461, 4, 682));
        queue_random(40);

        // One device, one zone: every zone-0 pair is already taken, so stripes and
        // singles run short, while an add beyond zone_count still marks its pair.
        start_phase(1, 1, 30, 30);
        queue_req(make_req(REQ_STRIPE, 5, 0, 0, 0));
        queue_req(make_req(REQ_MIRROR, 6, 0, 0, 0));
        queue_req(make_req(REQ_SINGLE, 0, 17, 6, 0));
        queue_req(make_req(REQ_ADD, 0, 18, 2, 900));
        queue_random(15);

        // Stripe width zero: stripes need no pairs and close with an empty ok result.
        start_phase(0, 3, 30, 30);
        queue_req(make_req(REQ_STRIPE, 1023, 0, 0, 0));
        queue_req(make_req(REQ_MIRROR, 0, 0, 0, 0));
        queue_req(make_req(REQ_SINGLE, 0, 99, 1, 0));
        queue_random(15);

        // Oversized registers act as the full array.  A mirrored stripe here yields the
        // largest number of results per request.  No idling on either side.
        start_phase(15, 2047, 0, 0);
        queue_req(make_req(REQ_MIRROR, 1023, 0, 0, 0));
        queue_req(make_req(REQ_STRIPE, 1023, 0, 0, 0));
        queue_random(60);

        // No zones to scan: every allocation runs short, adds still mark.
        start_phase(3, 0, 30, 30);
        queue_req(make_req(REQ_STRIPE, 2, 0, 0, 0));
        queue_req(make_req(REQ_MIRROR, 3, 0, 0, 0));
        queue_req(make_req(REQ_SINGLE, 0, 8191, 0, 0));
        queue_req(make_req(REQ_ADD, 0, 8190, 1, 0));
        queue_random(15);

        // A small window that fills up, with the sender pausing halfway until every
        // outstanding result has come back.
        start_phase(5, 40, 30, 30);
        queue_random(40);
        wait_drained();
        queue_random(40);

        start_phase(8, 1024, 40, 20);
        queue_random(70);

        start_phase(2, 1023, 20, 40);
        queue_random(40);

        start_phase(1, 1024, 30, 30);
        queue_req(make_req(REQ_MIRROR, 1023, 0, 0, 0));
        queue_random(20);

        // Everything owed has arrived; stay a little longer to catch stray results.
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0 && expected_maps.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
